// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Clock and reset names clk and rst_n must be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define PPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ppg_pkg.sv =====
// Package for the plasma pixel generator: word types, register codes, fixed-point
// constants, the quarter-wave sine table and small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps

package ppg_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int FRAME_BITS       = 16;

  localparam int SIN_LG = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR    = SINE_TABLE_DEPTH / 4;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int T_W    = FRAME_BITS + 12;  // frame * 0.05 in Q16
  localparam int ANG_W  = 30;               // signed Q16 angles
  localparam int R2_W   = 52;               // radius squared, Q32
  localparam int ROOT_W = R2_W / 2;         // radius, Q16
  localparam int TDLY   = 8 + ROOT_W;       // time carried to the radial angle
  localparam int VDLY   = 6 + ROOT_W;       // partial sine sum carried to the final add
  localparam int NSTAGE = 20 + ROOT_W;

  localparam logic [15:0] FRAME_MASK = 16'((64'd1 << FRAME_BITS) - 64'd1);

  localparam logic [9:0]  STEP_Q16       = 10'd983;
  localparam logic [11:0] TIME_Q16       = 12'd3277;
  localparam logic [17:0] PI_Q16         = 18'd205887;
  localparam logic [16:0] HALF_PI_Q16    = 17'd102944;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  // reciprocals for exact floor division by 5, 3 and 10
  localparam logic [28:0] RECIP5  = 29'd429496730;  // 2^31 / 5
  localparam logic [28:0] RECIP3  = 29'd357913942;  // 2^30 / 3
  localparam logic [25:0] RECIP10 = 26'd53687092;   // 2^29 / 10

  localparam longint unsigned HALF_PI_Q28 = 64'd421657428;
  localparam longint unsigned ONE_Q28     = 64'd268435456;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_WIDTH      = 2'd1,
    REG_HEIGHT     = 2'd2,
    REG_SCALE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]  column;
    logic [9:0]  row;
    logic [15:0] frame_number;
  } ppg_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ppg_out_t;

  typedef logic [14:0] qsin_tab_t [0:QTR];

  function automatic logic [14:0] quarter_sine(input longint unsigned u);
    longint unsigned a, a2, p, s, q;
    a  = HALF_PI_Q28 * u / SINE_TABLE_DEPTH;
    a2 = (a * a) >> 28;
    p  = ONE_Q28 - a2 / 72;
    p  = ONE_Q28 - ((a2 * p) >> 28) / 42;
    p  = ONE_Q28 - ((a2 * p) >> 28) / 20;
    p  = ONE_Q28 - ((a2 * p) >> 28) / 6;
    s  = (a * p) >> 28;
    q  = (s + 64'd4096) >> 13;
    if (q > 64'd32767) q = 64'd32767;
    return q[14:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    for (int j = 0; j <= QTR; j++) begin
      tab[j] = quarter_sine(longint'(4 * j));
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

  // turns of an angle, Q48 fraction
  function automatic logic [47:0] angle_frac(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W+30:0] p;
    p = a * $signed({1'b0, INV_TWO_PI_Q32});
    return p[47:0];
  endfunction

  // rounded table index, then quarter-wave symmetry
  function automatic logic signed [15:0] sine_of_frac(input logic [47:0] frac);
    logic [SIN_LG-1:0] idx;
    logic [SIN_LG-3:0] m;
    logic [SIN_LG-2:0] u;
    logic signed [15:0] val;
    idx = frac[47 -: SIN_LG] + SIN_LG'(frac[47-SIN_LG]);
    m   = idx[SIN_LG-3:0];
    u   = idx[SIN_LG-2] ? (SIN_LG-1)'(QTR) - {1'b0, m} : {1'b0, m};
    val = $signed({1'b0, QSIN[u]});
    return idx[SIN_LG-1] ? -val : val;
  endfunction

  // halve, rounding toward zero
  function automatic logic signed [ANG_W-1:0] half_tz(input logic signed [ANG_W:0] s);
    logic signed [ANG_W:0] q;
    q = s + $signed({{ANG_W{1'b0}}, s[ANG_W]});
    return q[ANG_W:1];
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [15:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 16'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

endpackage

// ===== src/plasma_pixel_generator.sv =====
// Plasma pixel generator top level: APB register file and the full pixel pipeline.
// Depends on ppg_pkg.
`timescale 1ns / 1ps

// channel  | direction | word
// in_      | in        | column, row, frame_number
// out_     | out       | red, green, blue
// cfg      | in/out    | APB: brightness, width, height, scale
//
// One word per clock while the output is not stalled; the square root resolves one bit
// per stage, and two sine lookups follow it.
// Synchronous active-low reset clears valid bits and loads the register defaults.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.

module plasma_pixel_generator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ppg_pkg::ppg_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ppg_pkg::ppg_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppg_pkg::ADDR_W-1:0]   paddr,
  input  logic [ppg_pkg::DATA_W-1:0]   pwdata,
  output logic [ppg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import ppg_pkg::*;

  logic signed [8:0] brightness_r;
  logic [10:0]       frame_width_r;
  logic [10:0]       frame_height_r;
  logic [4:0]        pixel_scale_r;
  reg_idx_t          reg_sel;

  logic [NSTAGE-1:0] vld_r;
  logic              en;

  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r   <= 9'sd64;
      frame_width_r  <= 11'd320;
      frame_height_r <= 11'd180;
      pixel_scale_r  <= 5'd4;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_BRIGHTNESS: brightness_r   <= $signed(pwdata[8:0]);
        REG_WIDTH:      frame_width_r  <= pwdata[10:0];
        REG_HEIGHT:     frame_height_r <= pwdata[10:0];
        REG_SCALE:      pixel_scale_r  <= pwdata[4:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BRIGHTNESS: prdata = {23'd0, brightness_r};
      REG_WIDTH:      prdata = {21'd0, frame_width_r};
      REG_HEIGHT:     prdata = {21'd0, frame_height_r};
      REG_SCALE:      prdata = {27'd0, pixel_scale_r};
      default:        prdata = '0;
    endcase
  end

  assign en        = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NSTAGE-2:0], in_valid};
  end

  // s1: centre offsets, step, time
  logic signed [10:0] s1_dx_r, s1_dy_r;
  logic [14:0]        s1_step_r;
  logic [T_W-1:0]     s1_t_r;
  logic [14:0]        step_full;
  logic [T_W-1:0]     t_full;
  logic [15:0]        frame_m;

  assign frame_m   = in_data.frame_number & FRAME_MASK;
  assign step_full = pixel_scale_r * STEP_Q16;
  assign t_full    = frame_m * TIME_Q16;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r   <= $signed({1'b0, in_data.column}) - $signed({1'b0, frame_width_r[10:1]});
      s1_dy_r   <= $signed({1'b0, in_data.row}) - $signed({1'b0, frame_height_r[10:1]});
      s1_step_r <= step_full;
      s1_t_r    <= t_full;
    end
  end

  // s2: scaled coordinates
  logic signed [25:0] s2_x_r, s2_y_r;
  logic [T_W-1:0]     s2_t_r;
  logic signed [26:0] x_full, y_full;

  assign x_full = s1_dx_r * $signed({1'b0, s1_step_r});
  assign y_full = s1_dy_r * $signed({1'b0, s1_step_r});

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x_r <= x_full[25:0];
      s2_y_r <= y_full[25:0];
      s2_t_r <= s1_t_r;
    end
  end

  // s3: constant divisions and the plain angles
  logic [25:0]            s3_t5_r;
  logic [26:0]            s3_t3_r;
  logic signed [22:0]     s3_x10_r, s3_y10_r;
  logic signed [ANG_W-1:0] s3_a0_r, s3_a1_r, s3_a2_r;
  logic [56:0]            t5_full, t3_full;
  logic [24:0]            ax, ay;
  logic [50:0]            qx_full, qy_full;
  logic signed [ANG_W-1:0] a0;
  logic signed [ANG_W:0]  sum_yt, sum_xyt;

  assign t5_full = s2_t_r * RECIP5;
  assign t3_full = s2_t_r * RECIP3;
  assign ax      = 25'(s2_x_r[25] ? -s2_x_r : s2_x_r);
  assign ay      = 25'(s2_y_r[25] ? -s2_y_r : s2_y_r);
  assign qx_full = ax * RECIP10;
  assign qy_full = ay * RECIP10;
  assign a0      = $signed({2'b0, s2_t_r}) + s2_x_r;
  assign sum_yt  = $signed({3'b0, s2_t_r}) + s2_y_r;
  assign sum_xyt = $signed({3'b0, s2_t_r}) + s2_y_r + s2_x_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t5_r  <= t5_full[56:31];
      s3_t3_r  <= t3_full[56:30];
      s3_x10_r <= s2_x_r[25] ? -$signed({1'b0, qx_full[50:29]}) : $signed({1'b0, qx_full[50:29]});
      s3_y10_r <= s2_y_r[25] ? -$signed({1'b0, qy_full[50:29]}) : $signed({1'b0, qy_full[50:29]});
      s3_a0_r  <= a0;
      s3_a1_r  <= half_tz(sum_yt);
      s3_a2_r  <= half_tz(sum_xyt);
    end
  end

  // s4..s6: five sine lookups
  logic signed [ANG_W-1:0] s4_ang_r [0:4];
  logic [47:0]             s5_frac_r [0:4];
  logic signed [15:0]      s6_sin_r [0:4];
  logic signed [22:0]      s4_x10_r, s4_y10_r, s5_x10_r, s5_y10_r, s6_x10_r, s6_y10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ang_r[0] <= s3_a0_r;
      s4_ang_r[1] <= s3_a1_r;
      s4_ang_r[2] <= s3_a2_r;
      s4_ang_r[3] <= $signed(ANG_W'(s3_t5_r));
      s4_ang_r[4] <= $signed(ANG_W'(s3_t3_r)) + $signed(ANG_W'(HALF_PI_Q16));
      s4_x10_r    <= s3_x10_r;
      s4_y10_r    <= s3_y10_r;
      for (int k = 0; k < 5; k++) begin
        s5_frac_r[k] <= angle_frac(s4_ang_r[k]);
        s6_sin_r[k]  <= sine_of_frac(s5_frac_r[k]);
      end
      s5_x10_r <= s4_x10_r;
      s5_y10_r <= s4_y10_r;
      s6_x10_r <= s5_x10_r;
      s6_y10_r <= s5_y10_r;
    end
  end

  // s7..s10: radius squared
  logic signed [23:0] s7_cx_r, s7_cy_r;
  logic signed [17:0] s7_vsum_r;
  logic [46:0]        s8_sqx_r, s8_sqy_r;
  logic [47:0]        s9_sum_r;
  logic signed [47:0] sqx_full, sqy_full;

  assign sqx_full = s7_cx_r * s7_cx_r;
  assign sqy_full = s7_cy_r * s7_cy_r;

  logic [R2_W-1:0]   sq_rem_r [0:ROOT_W-1];
  logic [ROOT_W-1:0] sq_root_r [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      s7_cx_r      <= s6_x10_r + s6_sin_r[3];
      s7_cy_r      <= s6_y10_r + s6_sin_r[4];
      s7_vsum_r    <= s6_sin_r[0] + s6_sin_r[1] + s6_sin_r[2];
      s8_sqx_r     <= sqx_full[46:0];
      s8_sqy_r     <= sqy_full[46:0];
      s9_sum_r     <= s8_sqx_r + s8_sqy_r;
      sq_rem_r[0]  <= (R2_W'(s9_sum_r) << 6) + (R2_W'(s9_sum_r) << 5)
                    + (R2_W'(s9_sum_r) << 2) + (R2_W'(1) << 32);
      sq_root_r[0] <= '0;
    end
  end

  // s11..: integer square root, one result bit per stage
  for (genvar g = 1; g <= ROOT_W; g++) begin : g_sqrt
    localparam int J = ROOT_W - g;
    logic [R2_W-1:0] trial;
    logic            fits;

    assign trial = (R2_W'(sq_root_r[g-1]) << (J + 1)) | (R2_W'(1) << (2 * J));
    assign fits  = sq_rem_r[g-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root_r[g] <= fits ? (sq_root_r[g-1] | (ROOT_W'(1) << J)) : sq_root_r[g-1];
      end
    end

    if (g < ROOT_W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) sq_rem_r[g] <= fits ? sq_rem_r[g-1] - trial : sq_rem_r[g-1];
      end
    end
  end

  logic [T_W-1:0]     t_dly_r [0:TDLY-1];
  logic signed [17:0] v_dly_r [0:VDLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      t_dly_r[0] <= s2_t_r;
      for (int i = 1; i < TDLY; i++) t_dly_r[i] <= t_dly_r[i-1];
      v_dly_r[0] <= s7_vsum_r;
      for (int i = 1; i < VDLY; i++) v_dly_r[i] <= v_dly_r[i-1];
    end
  end

  // radial sine, final sum, phase, color sines, channels
  logic signed [ANG_W-1:0] s37_ang_r;
  logic [47:0]             s38_frac_r;
  logic signed [15:0]      s39_sin_r;
  logic signed [18:0]      s40_v_r;
  logic signed [37:0]      s41_prod_r;
  logic signed [ANG_W-1:0] s42_ang_r [0:1];
  logic [47:0]             s43_frac_r [0:1];
  logic signed [15:0]      s44_sin_r [0:1];
  logic signed [31:0]      s45_red_r, s45_grn_r;
  ppg_out_t                out_data_r;

  logic signed [37:0] ph_full, ph_adj;
  logic signed [ANG_W-1:0] phase;
  logic signed [17:0] u_red, u_grn;
  logic signed [31:0] ch_red, ch_grn, blue_v;

  assign ph_full = s40_v_r * $signed({1'b0, PI_Q16});
  assign ph_adj  = s41_prod_r + (s41_prod_r[37] ? 38'sd65535 : 38'sd0);
  assign phase   = ANG_W'($signed(ph_adj[37:16]));
  assign u_red   = 18'sd32768 + s44_sin_r[0];
  assign u_grn   = 18'sd32768 + s44_sin_r[1];
  assign ch_red  = 4 * brightness_r * u_red + (brightness_r - 64) * 65536;
  assign ch_grn  = 4 * brightness_r * u_grn + (brightness_r - 64) * 65536;
  assign blue_v  = 4 * brightness_r - 255;

  always_ff @(posedge clk) begin
    if (en) begin
      s37_ang_r    <= $signed(ANG_W'(sq_root_r[ROOT_W])) + $signed(ANG_W'(t_dly_r[TDLY-1]));
      s38_frac_r   <= angle_frac(s37_ang_r);
      s39_sin_r    <= sine_of_frac(s38_frac_r);
      s40_v_r      <= v_dly_r[VDLY-1] + s39_sin_r;
      s41_prod_r   <= ph_full;
      s42_ang_r[0] <= phase;
      s42_ang_r[1] <= phase + $signed(ANG_W'(HALF_PI_Q16));
      for (int k = 0; k < 2; k++) begin
        s43_frac_r[k] <= angle_frac(s42_ang_r[k]);
        s44_sin_r[k]  <= sine_of_frac(s43_frac_r[k]);
      end
      s45_red_r        <= ch_red;
      s45_grn_r        <= ch_grn;
      out_data_r.red   <= clamp8(s45_red_r[31:16]);
      out_data_r.green <= clamp8(s45_grn_r[31:16]);
      out_data_r.blue  <= clamp8(blue_v[15:0]);
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== src/ppg_checker.sv =====
// Port-level checker for the plasma pixel generator, bound to the top level.
// Depends on ppg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input ppg_pkg::ppg_out_t          out_data,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [ppg_pkg::ADDR_W-1:0] paddr,
  input logic [ppg_pkg::DATA_W-1:0] pwdata,
  input logic [ppg_pkg::DATA_W-1:0] prdata,
  input logic                       pready
);
  import ppg_pkg::*;

  `PPG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output word changed while stalled")
  `PPG_ASSERT(a_ready_stall, !in_ready |-> out_valid && !out_ready, "input blocked without an output stall")
  `PPG_ASSERT(a_bright_rb, psel && penable && pwrite && pready && (paddr[3:2] == REG_BRIGHTNESS) |=> (paddr[3:2] != REG_BRIGHTNESS) || (prdata[8:0] == $past(pwdata[8:0])), "brightness readback mismatch")

endmodule

bind plasma_pixel_generator ppg_checker u_ppg_checker (.*);
